// ----- rtl/ghb_pkg.sv -----
package ghb_pkg;

	localparam int DEF_MAX_FRONTIER = 4;
	localparam int DEF_MAX_FEATURES = 16;
	localparam int DEF_NUM_BINS     = 256;
	localparam int DEF_MAX_ROWS     = 1048576;

	localparam int FRONT_SLOTS = 4;

	localparam int ACT_W    = 2;
	localparam int NODE_W   = 10;
	localparam int SLOT_W   = 2;
	localparam int FEAT_W   = 4;
	localparam int BIN_W    = 8;
	localparam int GRAD_W   = 16;
	localparam int HESS_W   = 15;
	localparam int SGRAD_W  = 36;
	localparam int SHESS_W  = 35;
	localparam int CNT_W    = 21;
	localparam int NFEAT_W  = 5;
	localparam int FCOUNT_W = 3;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [ACT_W-1:0] ACT_ACCUM = 2'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_ID_0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_ID_1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_ID_2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRONTIER_ID_3  = 3'd5;

	localparam logic [NFEAT_W-1:0] NUM_FEATURES_RST = 5'd16;

	typedef struct packed {
		logic [CNT_W-1:0]   row_count;
		logic [SHESS_W-1:0] sum_hess;
		logic [SGRAD_W-1:0] sum_grad;
	} cell_t;

endpackage

// ----- rtl/ghb_ram.sv -----
module ghb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/gradient_histogram_builder_top.sv -----
// Gradient histogram store for tree split search.
// Input items arrive on s_tvalid/s_tready: tuser carries the action
// (accumulate, read, clear), tdata the row fields. Only read items give a
// result, on m_tvalid/m_tready. Configuration goes in on cfg_valid/cfg_ready
// (always ready) as register index plus data.
// One item is taken per cycle while s_tready is high. The cell memory is read when an item is
// accepted and written back in the next cycle; an accumulate that hits the
// cell just being written takes the forwarded value, so back-to-back rows
// into the same bin run at full rate.
// A read result passes from the execute stage to the output register. If the
// receiver stalls with a result still held, the next read waits in the
// execute stage and input intake stops behind it; accumulates keep flowing
// while the output holds.
// Reset and every clear item start a sweep that zeroes the memory one cell
// per cycle, all MAX_FRONTIER * MAX_FEATURES * NUM_BINS cells (16384 at the
// defaults), during which s_tready is low. Config writes are taken anytime.
module gradient_histogram_builder_top
	import ghb_pkg::*;
#(
	parameter int MAX_FRONTIER = DEF_MAX_FRONTIER,
	parameter int MAX_FEATURES = DEF_MAX_FEATURES,
	parameter int NUM_BINS     = DEF_NUM_BINS,
	parameter int MAX_ROWS     = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// node_id, slot, feature_index, bin_value, grad, hess, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [ACT_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sum_grad, sum_hess, row_count, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = MAX_FRONTIER * MAX_FEATURES * NUM_BINS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $bits(cell_t);
	localparam logic [CNT_W-1:0] CNT_CAP =
		(MAX_ROWS < (2 ** CNT_W - 1)) ? CNT_W'(MAX_ROWS) : CNT_W'(2 ** CNT_W - 1);

	logic [NFEAT_W-1:0]  num_features_q;
	logic [FCOUNT_W-1:0] frontier_count_q;
	logic [NODE_W-1:0]   frontier_id_q [FRONT_SLOTS];

	logic [NODE_W-1:0] in_node;
	logic [SLOT_W-1:0] in_slot;
	logic [FEAT_W-1:0] in_feat;
	logic [BIN_W-1:0]  in_bin;
	logic [GRAD_W-1:0] in_grad;
	logic [HESS_W-1:0] in_hess;

	logic                accept;
	logic [FCOUNT_W-1:0] active;
	logic                hit;
	logic [SLOT_W-1:0]   hit_idx;
	logic                acc_ok;
	logic                rd_ok;
	logic [SLOT_W-1:0]   slot_sel;
	logic [BIN_W-1:0]    bin_sel;
	logic [AW-1:0]       addr_new;

	logic              valid_s1;
	logic [ACT_W-1:0]  act_s1;
	logic              acc_ok_s1;
	logic              rd_ok_s1;
	logic [AW-1:0]     addr_s1;
	logic [GRAD_W-1:0] grad_s1;
	logic [HESS_W-1:0] hess_s1;
	logic              fwd_s1;
	cell_t             fwd_data_q;
	logic              stall_s1;

	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	cell_t                ram_rdata;
	cell_t                cur;
	cell_t                upd;
	logic [SGRAD_W:0]     g_new;
	logic [SHESS_W:0]     h_new;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	cell_t                ram_wdata;
	logic                 ram_re;

	assign in_node = s_tdata[9:0];
	assign in_slot = s_tdata[11:10];
	assign in_feat = s_tdata[15:12];
	assign in_bin  = s_tdata[23:16];
	assign in_grad = s_tdata[39:24];
	assign in_hess = s_tdata[54:40];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_features_q   <= NUM_FEATURES_RST;
			frontier_count_q <= '0;
			for (int i = 0; i < FRONT_SLOTS; i++) begin
				frontier_id_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_FEATURES:   num_features_q   <= cfg_data[NFEAT_W-1:0];
				REG_FRONTIER_COUNT: frontier_count_q <= cfg_data[FCOUNT_W-1:0];
				REG_FRONTIER_ID_0:  frontier_id_q[0] <= cfg_data;
				REG_FRONTIER_ID_1:  frontier_id_q[1] <= cfg_data;
				REG_FRONTIER_ID_2:  frontier_id_q[2] <= cfg_data;
				REG_FRONTIER_ID_3:  frontier_id_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// lowest active slot whose id matches wins
	always_comb begin
		active  = (32'(frontier_count_q) > MAX_FRONTIER) ?
			FCOUNT_W'(MAX_FRONTIER) : frontier_count_q;
		hit     = 1'b0;
		hit_idx = '0;
		for (int s = 0; s < FRONT_SLOTS; s++) begin
			if (!hit && s < MAX_FRONTIER && FCOUNT_W'(s) < active &&
				frontier_id_q[s] == in_node) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(s);
			end
		end
	end

	always_comb begin
		acc_ok = (s_tuser == ACT_ACCUM) && hit &&
			({1'b0, in_feat} < num_features_q) && (32'(in_feat) < MAX_FEATURES);
		rd_ok  = (32'(in_slot) < MAX_FRONTIER) && (32'(in_feat) < MAX_FEATURES) &&
			(32'(in_bin) < NUM_BINS);
		if (s_tuser == ACT_ACCUM) begin
			slot_sel = hit_idx;
			bin_sel  = (32'(in_bin) >= NUM_BINS) ? BIN_W'(NUM_BINS - 1) : in_bin;
		end else begin
			slot_sel = in_slot;
			bin_sel  = in_bin;
		end
		addr_new = AW'((32'(slot_sel) * MAX_FEATURES + 32'(in_feat)) * NUM_BINS +
			32'(bin_sel));
	end

	assign stall_s1 = valid_s1 && (act_s1 == ACT_READ) && m_tvalid_q && !m_tready;
	assign s_tready = !clr_busy_q && !(valid_s1 && (stall_s1 || act_s1 == ACT_CLEAR));
	assign accept   = s_tvalid && s_tready;

	assign cur = fwd_s1 ? fwd_data_q : ram_rdata;

	always_comb begin
		g_new = {cur.sum_grad[SGRAD_W-1], cur.sum_grad} +
			{{(SGRAD_W + 1 - GRAD_W){grad_s1[GRAD_W-1]}}, grad_s1};
		h_new = {1'b0, cur.sum_hess} + (SHESS_W + 1)'(hess_s1);
		if (g_new[SGRAD_W] != g_new[SGRAD_W-1]) begin
			upd.sum_grad = g_new[SGRAD_W] ? {1'b1, {(SGRAD_W - 1){1'b0}}} :
				{1'b0, {(SGRAD_W - 1){1'b1}}};
		end else begin
			upd.sum_grad = g_new[SGRAD_W-1:0];
		end
		upd.sum_hess  = h_new[SHESS_W] ? {SHESS_W{1'b1}} : h_new[SHESS_W-1:0];
		upd.row_count = (cur.row_count < CNT_CAP) ? cur.row_count + 1'b1 :
			cur.row_count;
	end

	always_comb begin
		ram_we    = clr_busy_q || (valid_s1 && acc_ok_s1);
		ram_waddr = clr_busy_q ? clr_cnt_q : addr_s1;
		ram_wdata = clr_busy_q ? cell_t'('0) : upd;
		ram_re    = accept && (acc_ok || (s_tuser == ACT_READ && rd_ok));
	end

	ghb_ram #(
		.WIDTH(CW),
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_new),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			act_s1   <= ACT_ACCUM;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			act_s1   <= s_tuser;
			fwd_s1   <= valid_s1 && acc_ok_s1 && (addr_new == addr_s1);
		end else if (!stall_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_ok_s1  <= acc_ok;
			rd_ok_s1   <= rd_ok;
			addr_s1    <= addr_new;
			grad_s1    <= in_grad;
			hess_s1    <= in_hess;
			fwd_data_q <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == AW'(CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end else if (valid_s1 && act_s1 == ACT_CLEAR) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (valid_s1 && act_s1 == ACT_READ && !stall_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && act_s1 == ACT_READ && !stall_s1) begin
			m_tdata_q <= rd_ok_s1 ? OUT_DATA_W'(cur) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_clear_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("item taken during clear sweep");

	a_clear_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !valid_s1)
		else $error("execute stage busy during clear sweep");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		stall_s1 |=> valid_s1 && act_s1 == ACT_READ)
		else $error("stalled read lost from execute stage");

	a_fwd_follows_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 && acc_ok_s1 && addr_new == addr_s1 |=> fwd_s1)
		else $error("missing forward on same-cell update");

endmodule
